>>> design/scs_pkg.sv
package scs_pkg;

  // Milliseconds of audio carried by one frame decision
  localparam logic [15:0] FrameMs = 16'd30;

  // Register reset values
  localparam logic [15:0] MaxChunkMsRst    = 16'd30000;
  localparam logic [15:0] SilenceBoundRst  = 16'd600;
  localparam logic [15:0] MinChunkMsRst    = 16'd300;
  localparam logic [15:0] PeakThresholdRst = 16'd500;

  // Register indexes on the configuration port
  localparam logic [1:0] RegMaxChunk  = 2'd0;
  localparam logic [1:0] RegSilence   = 2'd1;
  localparam logic [1:0] RegMinChunk  = 2'd2;
  localparam logic [1:0] RegPeakThres = 2'd3;

  typedef enum logic [1:0] {
    OpFrame = 2'd0,
    OpFlush = 2'd1,
    OpClear = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        speech;
    logic [15:0] frame_peak;
  } item_t;

  typedef struct packed {
    logic [15:0] chunk_id;
    logic [15:0] length_ms;
    logic        flushed;
  } chunk_t;

  typedef struct packed {
    logic [15:0] chunk_limit_ms;
    logic [15:0] gap_end_ms;
    logic [15:0] voiced_min_ms;
    logic [15:0] peak_threshold;
  } cfg_t;

endpackage

>>> design/speech_chunk_segmenter_core.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i / in_stall_o   | in_data_i  (item_t)
// out     | output    | out_valid_o / out_stall_i | out_data_o (chunk_t)
// cfg     | input     | APB psel/penable/pready   | paddr, pwdata, prdata
//
// One item per cycle sustained while the output does not stall; an item's result reaches the
// output through the input register, then the state update into the result register.
// The rate is set by the state update in the engine.
// Reset clears the segmenter state and loads the register defaults.
// A stalled result holds the input register; a new item is taken once it moves on.
module speech_chunk_segmenter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  scs_pkg::item_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output scs_pkg::chunk_t    out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import scs_pkg::*;

  cfg_t   cfg;
  item_t  in_q;
  logic   in_valid_q, in_valid_d;
  chunk_t out_q, res;
  logic   out_valid_q, out_valid_d;
  logic   res_valid, out_free, adv, accept;

  scs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the held item when the result register can take its result
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  scs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .item_i      (in_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register
  assign in_valid_d = accept || (in_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // Result register
  assign out_valid_d = out_free ? (adv && res_valid) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result only appears after an item advanced
  a_res_from_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv))
    else $error("result appeared without an advancing item");

  // A held item is kept intact while the output stalls
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q && $stable(in_q))
    else $error("held item lost while stalled");

  // Frame-ended chunks are never marked final
  a_frame_not_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_valid && (in_q.opcode == OpFrame) |=> out_valid_q && !out_q.flushed)
    else $error("frame chunk marked final");

endmodule

>>> design/scs_cfg_regs.sv
module scs_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output scs_pkg::cfg_t      cfg_o
);
  import scs_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Decode the write transfer
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        RegMaxChunk:  cfg_d.chunk_limit_ms = pwdata[15:0];
        RegSilence:   cfg_d.gap_end_ms     = pwdata[15:0];
        RegMinChunk:  cfg_d.voiced_min_ms  = pwdata[15:0];
        RegPeakThres: cfg_d.peak_threshold = pwdata[15:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chunk_limit_ms <= MaxChunkMsRst;
      cfg_q.gap_end_ms     <= SilenceBoundRst;
      cfg_q.voiced_min_ms  <= MinChunkMsRst;
      cfg_q.peak_threshold <= PeakThresholdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Return the addressed register
  always_comb begin
    case (paddr[3:2])
      RegMaxChunk:  prdata = {16'd0, cfg_q.chunk_limit_ms};
      RegSilence:   prdata = {16'd0, cfg_q.gap_end_ms};
      RegMinChunk:  prdata = {16'd0, cfg_q.voiced_min_ms};
      RegPeakThres: prdata = {16'd0, cfg_q.peak_threshold};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/scs_engine.sv
module scs_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  scs_pkg::item_t  item_i,
  input  scs_pkg::cfg_t   cfg_i,
  output logic            res_valid_o,
  output scs_pkg::chunk_t res_o
);
  import scs_pkg::*;

  logic [15:0] buf_q, buf_d;
  logic [15:0] sil_q, sil_d;
  logic        utt_q, utt_d;
  logic [15:0] peak_q, peak_d;
  logic [15:0] id_q, id_d;

  logic [16:0] buf_sum, sil_sum;
  logic [15:0] buf_f, sil_f, peak_f, voiced;
  logic        utt_f, hit_max, hit_sil, emit;

  // Frame update ahead of the boundary checks
  always_comb begin
    buf_sum = {1'b0, buf_q} + {1'b0, FrameMs};
    sil_sum = {1'b0, sil_q} + {1'b0, FrameMs};
    buf_f   = buf_sum[16] ? 16'hFFFF : buf_sum[15:0];
    peak_f  = (item_i.frame_peak > peak_q) ? item_i.frame_peak : peak_q;
    utt_f   = utt_q | item_i.speech;
    if (item_i.speech) begin
      sil_f = 16'd0;
    end else if (utt_q) begin
      sil_f = sil_sum[16] ? 16'hFFFF : sil_sum[15:0];
    end else begin
      sil_f = sil_q;
    end
    voiced  = (buf_f > sil_f) ? (buf_f - sil_f) : 16'd0;
    hit_max = utt_f && (buf_f >= cfg_i.chunk_limit_ms);
    hit_sil = utt_f && (sil_f >= cfg_i.gap_end_ms)
              && (voiced >= cfg_i.voiced_min_ms);
  end

  // Next state and the chunk it produces
  always_comb begin
    buf_d  = buf_q;
    sil_d  = sil_q;
    utt_d  = utt_q;
    peak_d = peak_q;
    id_d   = id_q;
    emit   = 1'b0;
    res_o.chunk_id  = id_q;
    res_o.length_ms = buf_q;
    res_o.flushed   = 1'b0;
    if (step_i) begin
      case (op_e'(item_i.opcode))
        OpFrame: begin
          buf_d  = buf_f;
          sil_d  = sil_f;
          utt_d  = utt_f;
          peak_d = peak_f;
          res_o.length_ms = buf_f;
          if (hit_max || hit_sil) begin
            emit   = 1'b1;
            buf_d  = 16'd0;
            sil_d  = 16'd0;
            peak_d = 16'd0;
            id_d   = id_q + 16'd1;
            if (!hit_max) begin
              utt_d = 1'b0;
            end
          end
        end
        OpFlush: begin
          emit   = (buf_q != 16'd0) && (utt_q || (peak_q > cfg_i.peak_threshold));
          buf_d  = 16'd0;
          sil_d  = 16'd0;
          peak_d = 16'd0;
          utt_d  = 1'b0;
          res_o.flushed = 1'b1;
          if (emit) begin
            id_d = id_q + 16'd1;
          end
        end
        OpClear: begin
          buf_d  = 16'd0;
          sil_d  = 16'd0;
          peak_d = 16'd0;
          utt_d  = 1'b0;
          id_d   = 16'd0;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  assign res_valid_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= 16'd0;
      sil_q  <= 16'd0;
      utt_q  <= 1'b0;
      peak_q <= 16'd0;
      id_q   <= 16'd0;
    end else begin
      buf_q  <= buf_d;
      sil_q  <= sil_d;
      utt_q  <= utt_d;
      peak_q <= peak_d;
      id_q   <= id_d;
    end
  end

endmodule
